/* rtl/shared_buffer_threshold_manager_unit_macros.svh */
// Shared assertion macros for the threshold manager.
`ifndef SHARED_BUFFER_THRESHOLD_MANAGER_UNIT_MACROS_SVH
`define SHARED_BUFFER_THRESHOLD_MANAGER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SBTM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SBTM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sbtm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sbtm_pkg;

    localparam int PORTS     = 16;
    localparam int LEN_WIDTH = 16;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_BURST  = 2'd1,
        MODE_EVAC   = 2'd2
    } mode_t;

    typedef enum logic {
        OP_LENGTH = 1'b0,
        OP_DROP   = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        REG_BUFFER_SIZE       = 3'd0,
        REG_ALPHA_Q8          = 3'd1,
        REG_DEQUEUE_LIMIT     = 3'd2,
        REG_NET_ENQUEUE_LIMIT = 3'd3,
        REG_RATE_WINDOW_SHORT = 3'd4,
        REG_RATE_WINDOW_LONG  = 3'd5,
        REG_DROP_LIMIT        = 3'd6,
        REG_ACTIVE_PORTS      = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_SUM,
        ST_DYN,
        ST_DIV_BURST,
        ST_DIV_SHARE,
        ST_EMIT_READ,
        ST_EMIT_CALC
    } state_t;

    localparam int CNT_W = 16;
    localparam int TH_W  = 20;

    typedef struct packed {
        logic        op;
        logic [3:0]  port;
        logic [15:0] old_len;
        logic [15:0] new_len;
    } in_t;

    typedef struct packed {
        logic [3:0]  port_index;
        logic [15:0] threshold;
        logic        last_port;
    } out_t;

    typedef struct packed {
        logic [CNT_W-1:0] dequeue_count;
        logic [CNT_W-1:0] net_enqueue_count;
        logic [CNT_W-1:0] short_window_count;
        logic [CNT_W-1:0] long_window_count;
        logic [CNT_W-1:0] drop_count;
        logic             early_flag;
        mode_t            port_mode;
    } ctr_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

/* rtl/shared_buffer_threshold_manager_unit.sv */
// Operation: an event is read and then updated; a length event then walks the
// queue lengths, computes the dynamic value, runs two bit-serial divisions, and
// emits one threshold per active port, holding each one while m_ready is low.
// Only one event is taken at a time; a drop event ends after its update.
// Reset (aresetn, synchronous, active low) restores the register defaults and marks all
// per-port entries invalid, so they read as zero without a clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "shared_buffer_threshold_manager_unit_macros.svh"

module shared_buffer_threshold_manager_unit (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire sbtm_pkg::in_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output sbtm_pkg::out_t     m_data,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int PORTS     = sbtm_pkg::PORTS;
    localparam int LEN_WIDTH = sbtm_pkg::LEN_WIDTH;
    localparam int IDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int N_W   = $clog2(PORTS + 1);
    localparam logic [32:0] LEN_MAX = (33'd1 << LEN_WIDTH) - 33'd1;

    logic [15:0] buffer_size_reg, dequeue_limit_reg, net_enqueue_limit_reg;
    logic [15:0] rate_window_short_reg, rate_window_long_reg, drop_limit_reg;
    logic [11:0] alpha_q8_reg;
    logic [4:0]  active_ports_reg;

    sbtm_pkg::state_t state_reg, state_next;
    sbtm_pkg::in_t    item_reg, item_next;
    logic [N_W-1:0]       idx_reg, idx_next;
    logic                 pend_reg, pend_next;
    logic [LEN_WIDTH-1:0] sum_reg, sum_next;
    logic [LEN_WIDTH-1:0] total_reg, total_next;
    logic [N_W-1:0]       bursts_reg, bursts_next;
    logic [sbtm_pkg::TH_W-1:0] dyn_reg, dyn_next;
    logic [16:0]          rem_reg, rem_next;
    logic [15:0]          quo_reg, quo_next;
    logic [3:0]           div_cnt_reg, div_cnt_next;
    logic [15:0]          burst_share_reg, burst_share_next;
    logic [15:0]          share_reg, share_next;
    logic                 out_vld_reg, out_vld_next;
    sbtm_pkg::out_t       out_reg, out_next;

    sbtm_pkg::ctr_t       ctr_mem [PORTS];
    logic [LEN_WIDTH-1:0] qlen_mem [PORTS];
    logic [PORTS-1:0]     ctr_vld_reg, qlen_vld_reg;
    sbtm_pkg::ctr_t       ctr_q;
    logic [LEN_WIDTH-1:0] qlen_q;
    logic                 ctr_vq_reg, qlen_vq_reg;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr, wr_addr;
    logic                 ctr_we, qlen_we;
    sbtm_pkg::ctr_t       ctr_wd;
    logic [LEN_WIDTH-1:0] qlen_wd;

    sbtm_pkg::ctr_t       ctr_rd, ctr_upd;
    logic [LEN_WIDTH-1:0] qlen_rd;
    logic [N_W-1:0]       n_ports;
    logic                 accept, port_ok, out_free, last_idx;
    logic [LEN_WIDTH:0]   sum_add;
    logic [15:0]          diff;
    logic [27:0]          prod;
    logic [16:0]          rem_sh, dvsr, rem_step;
    logic                 div_ge;
    logic [15:0]          quo_step;
    logic [sbtm_pkg::TH_W-1:0] th, th_sat;
    logic                 evac_exit;

    assign pready  = 1'b1;
    assign s_ready = (state_reg == sbtm_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;
    assign out_free = !out_vld_reg || m_ready;

    always_comb begin
        if (active_ports_reg == 5'd0) begin
            n_ports = N_W'(1);
        end else if (32'(active_ports_reg) > PORTS) begin
            n_ports = N_W'(PORTS);
        end else begin
            n_ports = N_W'(active_ports_reg);
        end
    end

    assign port_ok  = 32'(s_data.port) < 32'(n_ports);
    assign last_idx = (idx_reg == n_ports - N_W'(1));
    assign ctr_rd   = ctr_vq_reg ? ctr_q : '0;
    assign qlen_rd  = qlen_vq_reg ? qlen_q : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_size_reg       <= 16'd175;
            alpha_q8_reg          <= 12'd256;
            dequeue_limit_reg     <= 16'd3;
            net_enqueue_limit_reg <= 16'd8;
            rate_window_short_reg <= 16'd200;
            rate_window_long_reg  <= 16'd1000;
            drop_limit_reg        <= 16'd175;
            active_ports_reg      <= 5'd16;
        end else if (psel && penable && pwrite) begin
            case (sbtm_pkg::reg_idx_t'(paddr[4:2]))
                sbtm_pkg::REG_BUFFER_SIZE:       buffer_size_reg       <= pwdata[15:0];
                sbtm_pkg::REG_ALPHA_Q8:          alpha_q8_reg          <= pwdata[11:0];
                sbtm_pkg::REG_DEQUEUE_LIMIT:     dequeue_limit_reg     <= pwdata[15:0];
                sbtm_pkg::REG_NET_ENQUEUE_LIMIT: net_enqueue_limit_reg <= pwdata[15:0];
                sbtm_pkg::REG_RATE_WINDOW_SHORT: rate_window_short_reg <= pwdata[15:0];
                sbtm_pkg::REG_RATE_WINDOW_LONG:  rate_window_long_reg  <= pwdata[15:0];
                sbtm_pkg::REG_DROP_LIMIT:        drop_limit_reg        <= pwdata[15:0];
                sbtm_pkg::REG_ACTIVE_PORTS:      active_ports_reg      <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sbtm_pkg::reg_idx_t'(paddr[4:2]))
            sbtm_pkg::REG_BUFFER_SIZE:       prdata = 32'(buffer_size_reg);
            sbtm_pkg::REG_ALPHA_Q8:          prdata = 32'(alpha_q8_reg);
            sbtm_pkg::REG_DEQUEUE_LIMIT:     prdata = 32'(dequeue_limit_reg);
            sbtm_pkg::REG_NET_ENQUEUE_LIMIT: prdata = 32'(net_enqueue_limit_reg);
            sbtm_pkg::REG_RATE_WINDOW_SHORT: prdata = 32'(rate_window_short_reg);
            sbtm_pkg::REG_RATE_WINDOW_LONG:  prdata = 32'(rate_window_long_reg);
            sbtm_pkg::REG_DROP_LIMIT:        prdata = 32'(drop_limit_reg);
            sbtm_pkg::REG_ACTIVE_PORTS:      prdata = 32'(active_ports_reg);
            default:                         prdata = 32'd0;
        endcase
    end

    // Per-port counter update for the event held in item_reg.
    always_comb begin
        ctr_upd = ctr_rd;
        if (item_reg.op == sbtm_pkg::OP_DROP) begin
            if (33'(total_reg) == 33'(buffer_size_reg)) begin
                ctr_upd.port_mode         = sbtm_pkg::MODE_NORMAL;
                ctr_upd.long_window_count = '0;
                ctr_upd.early_flag        = 1'b0;
            end
            ctr_upd.net_enqueue_count = '0;
            ctr_upd.dequeue_count     = '0;
            ctr_upd.drop_count        = sbtm_pkg::sat_inc(ctr_rd.drop_count);
            if (ctr_upd.drop_count == drop_limit_reg) begin
                ctr_upd.early_flag = 1'b0;
                ctr_upd.drop_count = '0;
                ctr_upd.port_mode  = sbtm_pkg::MODE_EVAC;
            end
        end else begin
            if (item_reg.old_len > item_reg.new_len) begin
                ctr_upd.dequeue_count = sbtm_pkg::sat_inc(ctr_rd.dequeue_count);
                if (ctr_upd.dequeue_count == dequeue_limit_reg) begin
                    ctr_upd.net_enqueue_count = '0;
                    ctr_upd.port_mode         = sbtm_pkg::MODE_NORMAL;
                    ctr_upd.long_window_count = '0;
                    ctr_upd.early_flag        = 1'b0;
                    ctr_upd.drop_count        = '0;
                end
                if (ctr_upd.net_enqueue_count != '0) begin
                    ctr_upd.net_enqueue_count = ctr_upd.net_enqueue_count - 1'b1;
                end
                ctr_upd.short_window_count = sbtm_pkg::sat_inc(ctr_rd.short_window_count);
                if (ctr_upd.short_window_count == rate_window_short_reg) begin
                    ctr_upd.short_window_count = '0;
                    ctr_upd.early_flag         = 1'b1;
                end
                if (ctr_upd.port_mode == sbtm_pkg::MODE_BURST) begin
                    ctr_upd.long_window_count =
                        sbtm_pkg::sat_inc(ctr_upd.long_window_count);
                    if (ctr_upd.long_window_count == rate_window_long_reg) begin
                        ctr_upd.port_mode  = sbtm_pkg::MODE_NORMAL;
                        ctr_upd.early_flag = 1'b0;
                    end
                end
            end else begin
                ctr_upd.dequeue_count     = '0;
                ctr_upd.net_enqueue_count = sbtm_pkg::sat_inc(ctr_rd.net_enqueue_count);
                if (ctr_upd.net_enqueue_count == net_enqueue_limit_reg) begin
                    ctr_upd.port_mode  = sbtm_pkg::MODE_BURST;
                    ctr_upd.early_flag = 1'b1;
                end
            end
            if (ctr_upd.early_flag) begin
                ctr_upd.net_enqueue_count  = '0;
                ctr_upd.short_window_count = '0;
                ctr_upd.early_flag = (ctr_upd.port_mode == sbtm_pkg::MODE_BURST);
            end
        end
    end

    assign sum_add = {1'b0, sum_reg} + {1'b0, qlen_rd};
    assign diff    = (33'(buffer_size_reg) > 33'(sum_reg))
                     ? 16'(33'(buffer_size_reg) - 33'(sum_reg)) : 16'd0;
    assign prod    = 28'(alpha_q8_reg) * 28'(diff);

    assign dvsr     = (state_reg == sbtm_pkg::ST_DIV_BURST) ? 17'(bursts_reg) : 17'(n_ports);
    assign rem_sh   = {rem_reg[15:0], buffer_size_reg[4'd15 - div_cnt_reg]};
    assign div_ge   = rem_sh >= dvsr;
    assign rem_step = div_ge ? rem_sh - dvsr : rem_sh;
    assign quo_step = {quo_reg[14:0], div_ge};

    always_comb begin
        case (ctr_rd.port_mode)
            sbtm_pkg::MODE_BURST: th = sbtm_pkg::TH_W'(burst_share_reg);
            sbtm_pkg::MODE_EVAC:  th = (sbtm_pkg::TH_W'(share_reg) < dyn_reg)
                                       ? sbtm_pkg::TH_W'(share_reg) : dyn_reg;
            default:              th = dyn_reg;
        endcase
        th_sat    = (33'(th) > LEN_MAX) ? sbtm_pkg::TH_W'(LEN_MAX) : th;
        evac_exit = (ctr_rd.port_mode == sbtm_pkg::MODE_EVAC)
                    && (33'(th_sat) > (33'(qlen_rd) << 1));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sbtm_pkg::ST_IDLE: begin
                if (accept && port_ok) begin
                    state_next = sbtm_pkg::ST_READ;
                end
            end
            sbtm_pkg::ST_READ: begin
                state_next = sbtm_pkg::ST_UPDATE;
            end
            sbtm_pkg::ST_UPDATE: begin
                state_next = (item_reg.op == sbtm_pkg::OP_DROP)
                             ? sbtm_pkg::ST_IDLE : sbtm_pkg::ST_SUM;
            end
            sbtm_pkg::ST_SUM: begin
                if ((idx_reg == n_ports) && !pend_reg) begin
                    state_next = sbtm_pkg::ST_DYN;
                end
            end
            sbtm_pkg::ST_DYN: begin
                state_next = sbtm_pkg::ST_DIV_BURST;
            end
            sbtm_pkg::ST_DIV_BURST: begin
                if (div_cnt_reg == 4'd15) begin
                    state_next = sbtm_pkg::ST_DIV_SHARE;
                end
            end
            sbtm_pkg::ST_DIV_SHARE: begin
                if (div_cnt_reg == 4'd15) begin
                    state_next = sbtm_pkg::ST_EMIT_READ;
                end
            end
            sbtm_pkg::ST_EMIT_READ: begin
                state_next = sbtm_pkg::ST_EMIT_CALC;
            end
            sbtm_pkg::ST_EMIT_CALC: begin
                if (out_free) begin
                    state_next = last_idx ? sbtm_pkg::ST_IDLE : sbtm_pkg::ST_EMIT_READ;
                end
            end
            default: begin
                state_next = sbtm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        item_next        = item_reg;
        idx_next         = idx_reg;
        pend_next        = 1'b0;
        sum_next         = sum_reg;
        total_next       = total_reg;
        bursts_next      = bursts_reg;
        dyn_next         = dyn_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        div_cnt_next     = div_cnt_reg;
        burst_share_next = burst_share_reg;
        share_next       = share_reg;
        out_vld_next     = out_vld_reg && !m_ready;
        out_next         = out_reg;
        rd_en            = 1'b0;
        rd_addr          = idx_reg[IDX_W-1:0];
        wr_addr          = idx_reg[IDX_W-1:0];
        ctr_we           = 1'b0;
        ctr_wd           = ctr_upd;
        qlen_we          = 1'b0;
        qlen_wd          = (33'(item_reg.new_len) > LEN_MAX)
                           ? LEN_MAX[LEN_WIDTH-1:0] : LEN_WIDTH'(item_reg.new_len);
        case (state_reg)
            sbtm_pkg::ST_IDLE: begin
                if (accept) begin
                    item_next = s_data;
                end
            end
            sbtm_pkg::ST_READ: begin
                rd_en   = 1'b1;
                rd_addr = IDX_W'(item_reg.port);
            end
            sbtm_pkg::ST_UPDATE: begin
                wr_addr     = IDX_W'(item_reg.port);
                ctr_we      = 1'b1;
                qlen_we     = (item_reg.op == sbtm_pkg::OP_LENGTH);
                idx_next    = '0;
                sum_next    = '0;
                bursts_next = '0;
            end
            sbtm_pkg::ST_SUM: begin
                if (idx_reg != n_ports) begin
                    rd_en     = 1'b1;
                    idx_next  = idx_reg + N_W'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    sum_next = sum_add[LEN_WIDTH] ? LEN_MAX[LEN_WIDTH-1:0]
                                                  : sum_add[LEN_WIDTH-1:0];
                    bursts_next = bursts_reg
                        + N_W'(ctr_rd.port_mode == sbtm_pkg::MODE_BURST);
                end
            end
            sbtm_pkg::ST_DYN: begin
                total_next   = sum_reg;
                dyn_next     = prod[27:8];
                rem_next     = '0;
                quo_next     = '0;
                div_cnt_next = '0;
            end
            sbtm_pkg::ST_DIV_BURST, sbtm_pkg::ST_DIV_SHARE: begin
                rem_next     = rem_step;
                quo_next     = quo_step;
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_cnt_reg == 4'd15) begin
                    rem_next = '0;
                    quo_next = '0;
                    idx_next = '0;
                    if (state_reg == sbtm_pkg::ST_DIV_BURST) begin
                        burst_share_next = (bursts_reg == '0) ? 16'd0 : quo_step;
                    end else begin
                        share_next = quo_step;
                    end
                end
            end
            sbtm_pkg::ST_EMIT_READ: begin
                rd_en = 1'b1;
            end
            sbtm_pkg::ST_EMIT_CALC: begin
                if (out_free) begin
                    out_vld_next         = 1'b1;
                    out_next.port_index  = 4'(idx_reg);
                    out_next.threshold   = 16'(th_sat);
                    out_next.last_port   = last_idx;
                    ctr_wd               = ctr_rd;
                    ctr_wd.port_mode     = sbtm_pkg::MODE_NORMAL;
                    ctr_wd.drop_count    = '0;
                    ctr_we               = evac_exit;
                    idx_next             = idx_reg + N_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sbtm_pkg::ST_IDLE;
            out_vld_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            total_reg    <= '0;
            ctr_vld_reg  <= '0;
            qlen_vld_reg <= '0;
            ctr_vq_reg   <= 1'b0;
            qlen_vq_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            pend_reg    <= pend_next;
            total_reg   <= total_next;
            if (ctr_we) begin
                ctr_vld_reg[wr_addr] <= 1'b1;
            end
            if (qlen_we) begin
                qlen_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                ctr_vq_reg  <= ctr_vld_reg[rd_addr];
                qlen_vq_reg <= qlen_vld_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg        <= item_next;
        idx_reg         <= idx_next;
        sum_reg         <= sum_next;
        bursts_reg      <= bursts_next;
        dyn_reg         <= dyn_next;
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        div_cnt_reg     <= div_cnt_next;
        burst_share_reg <= burst_share_next;
        share_reg       <= share_next;
        out_reg         <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (ctr_we) begin
            ctr_mem[wr_addr] <= ctr_wd;
        end
        if (qlen_we) begin
            qlen_mem[wr_addr] <= qlen_wd;
        end
        if (rd_en) begin
            ctr_q  <= ctr_mem[rd_addr];
            qlen_q <= qlen_mem[rd_addr];
        end
    end

    `SBTM_ASSERT_IMP(a_out_port_range, m_valid, (8'(m_data.port_index) < 8'(n_ports)), "threshold for inactive port")
    `SBTM_ASSERT_IMP(a_write_states, ctr_we, (state_reg == sbtm_pkg::ST_UPDATE || state_reg == sbtm_pkg::ST_EMIT_CALC), "counter write outside update")
    `SBTM_ASSERT_NXT(a_one_event, (s_valid && s_ready && port_ok), !s_ready, "second transaction taken while busy")

endmodule

`default_nettype wire

/* tb/shared_buffer_threshold_manager_unit_test.sv */
`timescale 1ns / 1ps
`default_nettype none

module shared_buffer_threshold_manager_unit_test;

    localparam int NPORT = 16;
    localparam int ITEMS_PER_PHASE = 56;
    localparam int NPHASE = 8;
    localparam int SETTLE = 160;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    sbtm_pkg::in_t s_data;
    logic m_valid;
    logic m_ready;
    sbtm_pkg::out_t m_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    shared_buffer_threshold_manager_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Register copy and per-port state of the threshold predictor.
    logic [15:0] cfg [8];
    logic [15:0] q_len [NPORT];
    logic [15:0] total_use;
    logic [15:0] deq_cnt [NPORT];
    logic [15:0] enq_cnt [NPORT];
    logic [15:0] short_cnt [NPORT];
    logic [15:0] long_cnt [NPORT];
    logic [15:0] drop_cnt [NPORT];
    logic early [NPORT];
    sbtm_pkg::mode_t mode [NPORT];

    sbtm_pkg::out_t thresholds_due [$];
    bit failed;
    bit hold_req;
    int burst_left;

    typedef struct {
        sbtm_pkg::in_t item;
        int th0;
    } row_t;

    function automatic logic [15:0] inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic int active_count();
        int a;
        a = cfg[sbtm_pkg::REG_ACTIVE_PORTS] & 5'h1F;
        if (a == 0) return 1;
        if (a > NPORT) return NPORT;
        return a;
    endfunction

    task automatic count_dequeue(input int p);
        deq_cnt[p] = inc16(deq_cnt[p]);
        if (deq_cnt[p] == cfg[sbtm_pkg::REG_DEQUEUE_LIMIT]) begin
            enq_cnt[p] = 0;
            mode[p] = sbtm_pkg::MODE_NORMAL;
            long_cnt[p] = 0;
            early[p] = 0;
            drop_cnt[p] = 0;
        end
        if (enq_cnt[p] > 0) enq_cnt[p] = enq_cnt[p] - 16'd1;
        short_cnt[p] = inc16(short_cnt[p]);
        if (short_cnt[p] == cfg[sbtm_pkg::REG_RATE_WINDOW_SHORT]) begin
            short_cnt[p] = 0;
            early[p] = 1;
        end
        if (mode[p] == sbtm_pkg::MODE_BURST) begin
            long_cnt[p] = inc16(long_cnt[p]);
            if (long_cnt[p] == cfg[sbtm_pkg::REG_RATE_WINDOW_LONG]) begin
                mode[p] = sbtm_pkg::MODE_NORMAL;
                early[p] = 0;
            end
        end
    endtask

    task automatic count_enqueue(input int p);
        deq_cnt[p] = 0;
        enq_cnt[p] = inc16(enq_cnt[p]);
        if (enq_cnt[p] == cfg[sbtm_pkg::REG_NET_ENQUEUE_LIMIT]) begin
            mode[p] = sbtm_pkg::MODE_BURST;
            early[p] = 1;
        end
    endtask

    task automatic count_drop(input int p);
        if (total_use == cfg[sbtm_pkg::REG_BUFFER_SIZE]) begin
            mode[p] = sbtm_pkg::MODE_NORMAL;
            long_cnt[p] = 0;
            early[p] = 0;
        end
        enq_cnt[p] = 0;
        deq_cnt[p] = 0;
        drop_cnt[p] = inc16(drop_cnt[p]);
        if (drop_cnt[p] == cfg[sbtm_pkg::REG_DROP_LIMIT]) begin
            early[p] = 0;
            drop_cnt[p] = 0;
            mode[p] = sbtm_pkg::MODE_EVAC;
        end
    endtask

    // Applies one accepted event and queues the thresholds it produces.
    task automatic predict_thresholds(input sbtm_pkg::in_t x);
        int n;
        int p;
        int bursts;
        longint sum;
        longint dyn;
        longint th;
        longint share;
        sbtm_pkg::out_t r;
        n = active_count();
        p = x.port;
        if (p >= n) return;
        if (x.op == sbtm_pkg::OP_DROP) begin
            count_drop(p);
            return;
        end
        if (x.old_len > x.new_len) count_dequeue(p);
        else count_enqueue(p);
        if (early[p]) begin
            enq_cnt[p] = 0;
            short_cnt[p] = 0;
            early[p] = (mode[p] == sbtm_pkg::MODE_BURST);
        end
        q_len[p] = x.new_len;
        sum = 0;
        bursts = 0;
        for (int i = 0; i < n; i++) begin
            sum += q_len[i];
            if (mode[i] == sbtm_pkg::MODE_BURST) bursts++;
        end
        if (sum > 65535) sum = 65535;
        total_use = sum[15:0];
        dyn = 0;
        if (cfg[sbtm_pkg::REG_BUFFER_SIZE] > total_use)
            dyn = (longint'(cfg[sbtm_pkg::REG_ALPHA_Q8] & 12'hFFF)
                   * longint'(cfg[sbtm_pkg::REG_BUFFER_SIZE] - total_use)) >>> 8;
        for (int i = 0; i < n; i++) begin
            th = dyn;
            if (mode[i] == sbtm_pkg::MODE_BURST) begin
                th = (bursts != 0) ? cfg[sbtm_pkg::REG_BUFFER_SIZE] / bursts : 0;
            end else if (mode[i] == sbtm_pkg::MODE_EVAC) begin
                share = cfg[sbtm_pkg::REG_BUFFER_SIZE] / n;
                if (share < th) th = share;
            end
            if (th > 65535) th = 65535;
            r.port_index = i;
            r.threshold = th[15:0];
            r.last_port = (i == n - 1);
            thresholds_due.push_back(r);
            if (mode[i] == sbtm_pkg::MODE_EVAC && th > 2 * longint'(q_len[i])) begin
                mode[i] = sbtm_pkg::MODE_NORMAL;
                drop_cnt[i] = 0;
            end
        end
    endtask

    // Offers one event and holds it until the handshake; th0 >= 0 types in the
    // expected threshold of port 0.
    task automatic send_event(input sbtm_pkg::in_t x, input int th0);
        int base;
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
        s_valid <= 1'b1;
        s_data <= x;
        do @(posedge aclk); while (!(s_valid && s_ready));
        base = thresholds_due.size();
        predict_thresholds(x);
        if (th0 >= 0 && thresholds_due.size() > base)
            thresholds_due[base].threshold = th0;
        if (burst_left == 0) s_valid <= 1'b0;
    endtask

    task automatic write_reg(input sbtm_pkg::reg_idx_t idx, input logic [31:0] v);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg[idx] = (idx == sbtm_pkg::REG_ALPHA_Q8) ? (v & 32'hFFF) :
                   (idx == sbtm_pkg::REG_ACTIVE_PORTS) ? (v & 32'h1F) : v[15:0];
    endtask

    // Ends the current burst so that an accepted transaction is not offered again.
    task automatic wait_drained();
        if (burst_left != 0) s_valid <= 1'b0;
        burst_left = 0;
        while (thresholds_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic sbtm_pkg::in_t random_event();
        sbtm_pkg::in_t x;
        int r;
        int n;
        int p;
        int others;
        int nl;
        n = active_count();
        r = $urandom_range(0, 99);
        x = $urandom;
        x.old_len = $urandom;
        x.new_len = $urandom;
        if (r < 12) return x;
        p = $urandom_range(0, n - 1);
        x.port = p;
        if (r < 27) begin
            x.op = sbtm_pkg::OP_DROP;
            return x;
        end
        x.op = sbtm_pkg::OP_LENGTH;
        x.old_len = q_len[p];
        if (r < 60) begin
            nl = q_len[p] + $urandom_range(0, 3);
        end else if (r < 90) begin
            nl = (q_len[p] > 0) ? q_len[p] - $urandom_range(1, 3) : 0;
            if (nl < 0) nl = 0;
        end else begin
            others = 0;
            for (int i = 0; i < n; i++) if (i != p) others += q_len[i];
            nl = cfg[sbtm_pkg::REG_BUFFER_SIZE] - others;
            if (nl < 0) nl = q_len[p];
        end
        if (nl > 65535) nl = 65535;
        x.new_len = nl;
        return x;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_req = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0: m_ready <= 1'b1;
                    1: m_ready <= $urandom_range(0, 1);
                    2: m_ready <= ($urandom_range(0, 4) != 0);
                    default: m_ready <= ($urandom_range(0, 4) == 0);
                endcase
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (thresholds_due.size() == 0) begin
                $error("unexpected threshold transaction for port %0d", m_data.port_index);
                failed = 1;
            end else begin
                if (m_data.port_index !== thresholds_due[0].port_index) begin
                    $error("port_index expected %0d actual %0d",
                           thresholds_due[0].port_index, m_data.port_index);
                    failed = 1;
                end
                if (m_data.threshold !== thresholds_due[0].threshold) begin
                    $error("threshold expected %0d actual %0d",
                           thresholds_due[0].threshold, m_data.threshold);
                    failed = 1;
                end
                if (m_data.last_port !== thresholds_due[0].last_port) begin
                    $error("last_port expected %0d actual %0d",
                           thresholds_due[0].last_port, m_data.last_port);
                    failed = 1;
                end
                void'(thresholds_due.pop_front());
            end
        end
    end

    initial begin
        row_t rows [6];
        logic [15:0] phase_cfg [NPHASE][8];
        failed = 0;
        hold_req = 0;
        burst_left = 0;
        s_valid <= 1'b0;
        s_data <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        aresetn <= 1'b0;
        cfg = '{16'd175, 16'd256, 16'd3, 16'd8, 16'd200, 16'd1000, 16'd175, 16'd16};
        for (int i = 0; i < NPORT; i++) begin
            q_len[i] = 0; deq_cnt[i] = 0; enq_cnt[i] = 0; short_cnt[i] = 0;
            long_cnt[i] = 0; drop_cnt[i] = 0; early[i] = 0;
            mode[i] = sbtm_pkg::MODE_NORMAL;
        end
        total_use = 0;
        phase_cfg = '{
            '{16'd175, 16'd256, 16'd3, 16'd8, 16'd200, 16'd1000, 16'd175, 16'd16},
            '{16'd65535, 16'd4095, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
              16'd65535, 16'd31},
            '{16'd1, 16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1},
            '{16'd40, 16'd128, 16'd4, 16'd5, 16'd6, 16'd9, 16'd3, 16'd4},
            '{16'd30, 16'd300, 16'd2, 16'd3, 16'd10, 16'd4, 16'd2, 16'd0},
            '{16'd60, 16'd512, 16'd5, 16'd4, 16'd7, 16'd6, 16'd4, 16'd16},
            '{16'd25, 16'd1000, 16'd3, 16'd2, 16'd5, 16'd3, 16'd2, 16'd8},
            '{16'd100, 16'd64, 16'd6, 16'd3, 16'd20, 16'd5, 16'd3, 16'd7}
        };
        rows = '{
            '{'{sbtm_pkg::OP_LENGTH, 4'd0, 16'd0, 16'd0}, 175},
            '{'{sbtm_pkg::OP_LENGTH, 4'd15, 16'd0, 16'hFFFF}, 0},
            '{'{sbtm_pkg::OP_LENGTH, 4'd15, 16'hFFFF, 16'd0}, 175},
            '{'{sbtm_pkg::OP_DROP, 4'd3, 16'hFFFF, 16'hFFFF}, -1},
            '{'{sbtm_pkg::OP_LENGTH, 4'd0, 16'd0, 16'd100}, 75},
            '{'{sbtm_pkg::OP_LENGTH, 4'd7, 16'd9, 16'd5}, -1}
        };
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[k]) send_event(rows[k].item, rows[k].th0);

        for (int ph = 0; ph < NPHASE; ph++) begin
            wait_drained();
            for (int r = 0; r < 8; r++) begin
                write_reg(sbtm_pkg::reg_idx_t'(r), phase_cfg[ph][r]);
            end
            if (ph == 5) hold_req = 1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) send_event(random_event(), -1);
        end
        wait_drained();

        if (!failed) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
